// ===== rtl/uidq_pkg.sv =====
// Package: codes, field widths and default sizes for the unique-ID FIFO queue.
`timescale 1ns / 1ps
`default_nettype none

package uidq_pkg;

    // Field widths of the stream payload
    localparam int MODE_W   = 3;
    localparam int REC_W    = 16;
    localparam int STATUS_W = 3;

    // Default sizes
    localparam int DEF_DEPTH    = 32;
    localparam int DEF_ID_WIDTH = 16;

    // Command modes
    localparam logic [MODE_W-1:0] MODE_JOIN   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SERVE  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LIST   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FINISH = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLOSE  = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_DUP   = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_LEFT  = 3'd4;

endpackage

`default_nettype wire

// ===== rtl/uidq_mem.sv =====
// Entry store: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module uidq_mem
    import uidq_pkg::*;
#(
    parameter int DEPTH = DEF_DEPTH,
    parameter int WIDTH = DEF_ID_WIDTH
)
(
    input  wire logic                     clk,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/uidq_ctrl.sv =====
// Queue controller: pointers, duplicate scan, list sequencing and output register.
`timescale 1ns / 1ps
`default_nettype none

module uidq_ctrl
    import uidq_pkg::*;
#(
    parameter int DEPTH    = DEF_DEPTH,
    parameter int ID_WIDTH = DEF_ID_WIDTH
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // command side
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [MODE_W-1:0]         in_mode,
    input  wire logic [ID_WIDTH-1:0]       in_id,
    // result side
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic      [STATUS_W-1:0]       out_status,
    output logic      [REC_W-1:0]          out_id,
    output logic                           out_last,
    // entry store
    output logic                           rd_en,
    output logic      [$clog2(DEPTH)-1:0]  rd_addr,
    input  wire logic [ID_WIDTH-1:0]       rd_data,
    output logic                           wr_en,
    output logic      [$clog2(DEPTH)-1:0]  wr_addr,
    output logic      [ID_WIDTH-1:0]       wr_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_JOIN_RES,
        S_SRV_OUT,
        S_LIST_OUT,
        S_ONE_RES
    } state_t;

    state_t                state_reg;
    logic [PW-1:0]         head_reg;
    logic [PW-1:0]         tail_reg;
    logic [CW-1:0]         fill_reg;
    logic [PW-1:0]         scan_ptr_reg;
    logic [CW-1:0]         cnt_reg;
    logic                  pend_reg;
    logic                  dup_reg;
    logic                  clr_reg;
    logic [STATUS_W-1:0]   res_status_reg;
    logic [ID_WIDTH-1:0]   id_reg;

    logic                  out_valid_reg;
    logic [STATUS_W-1:0]   out_status_reg;
    logic [REC_W-1:0]      out_id_reg;
    logic                  out_last_reg;

    logic                  out_free;
    logic                  out_load;
    logic                  accept;
    logic                  list_mode;
    logic                  scan_done;
    logic                  join_ok;
    logic [31:0]           rd_wide;
    logic [REC_W-1:0]      rd_id;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        wrap_inc = (p == LAST_SLOT) ? '0 : p + 1'b1;
    endfunction

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_id     = out_id_reg;
    assign out_last   = out_last_reg;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_load  = out_free && ((state_reg == S_JOIN_RES) || (state_reg == S_SRV_OUT)
                                    || (state_reg == S_LIST_OUT) || (state_reg == S_ONE_RES));
    assign accept    = in_valid && in_ready;
    assign list_mode = (in_mode == MODE_LIST) || (in_mode == MODE_FINISH);
    assign scan_done = (cnt_reg == fill_reg) && !pend_reg;
    assign join_ok   = !dup_reg && (fill_reg != FULL_CNT);
    assign rd_wide   = 32'(rd_data);
    assign rd_id     = rd_wide[REC_W-1:0];

    // Store port control; writes only happen with no read in flight
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = head_reg;
        wr_en   = 1'b0;
        wr_addr = tail_reg;
        wr_data = id_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (fill_reg != '0) && ((in_mode == MODE_SERVE) || list_mode))
                begin
                    rd_en = 1'b1;
                end
            end
            S_SCAN:
            begin
                if (cnt_reg != fill_reg)
                begin
                    rd_en   = 1'b1;
                    rd_addr = scan_ptr_reg;
                end
            end
            S_LIST_OUT:
            begin
                if (out_free && (cnt_reg != fill_reg))
                begin
                    rd_en   = 1'b1;
                    rd_addr = scan_ptr_reg;
                end
            end
            S_JOIN_RES:
            begin
                wr_en = out_free && join_ok;
            end
            default:
            begin
            end
        endcase
    end

    // Sequencer, queue pointers and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_reg       <= '0;
            tail_reg       <= '0;
            fill_reg       <= '0;
            scan_ptr_reg   <= '0;
            cnt_reg        <= '0;
            pend_reg       <= 1'b0;
            dup_reg        <= 1'b0;
            clr_reg        <= 1'b0;
            res_status_reg <= STAT_OK;
            id_reg         <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= STAT_OK;
            out_id_reg     <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            // result valid: set on a load, cleared once taken
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        id_reg <= in_id;
                        priority if (in_mode == MODE_JOIN)
                        begin
                            scan_ptr_reg <= head_reg;
                            cnt_reg      <= '0;
                            pend_reg     <= 1'b0;
                            dup_reg      <= 1'b0;
                            state_reg    <= S_SCAN;
                        end
                        else if (in_mode == MODE_SERVE)
                        begin
                            res_status_reg <= STAT_EMPTY;
                            clr_reg        <= 1'b0;
                            state_reg      <= (fill_reg == '0) ? S_ONE_RES : S_SRV_OUT;
                        end
                        else if (list_mode)
                        begin
                            res_status_reg <= STAT_EMPTY;
                            clr_reg        <= (in_mode == MODE_FINISH);
                            scan_ptr_reg   <= wrap_inc(head_reg);
                            cnt_reg        <= CW'(1);
                            state_reg      <= (fill_reg == '0) ? S_ONE_RES : S_LIST_OUT;
                        end
                        else if (in_mode == MODE_CLOSE)
                        begin
                            res_status_reg <= (fill_reg != '0) ? STAT_LEFT : STAT_OK;
                            clr_reg        <= 1'b1;
                            state_reg      <= S_ONE_RES;
                        end
                        else
                        begin
                            // unused mode: no result
                            state_reg <= S_IDLE;
                        end
                    end
                end

                S_SCAN:
                begin
                    // one read issued and one compare made per cycle
                    pend_reg <= rd_en;
                    if (rd_en)
                    begin
                        scan_ptr_reg <= wrap_inc(scan_ptr_reg);
                        cnt_reg      <= cnt_reg + 1'b1;
                    end
                    if (pend_reg && (rd_data == id_reg))
                    begin
                        dup_reg <= 1'b1;
                    end
                    if (scan_done)
                    begin
                        state_reg <= S_JOIN_RES;
                    end
                end

                S_JOIN_RES:
                begin
                    if (out_free)
                    begin
                        out_id_reg    <= '0;
                        out_last_reg  <= 1'b1;
                        priority if (dup_reg)
                        begin
                            out_status_reg <= STAT_DUP;
                        end
                        else if (fill_reg == FULL_CNT)
                        begin
                            out_status_reg <= STAT_FULL;
                        end
                        else
                        begin
                            out_status_reg <= STAT_OK;
                            tail_reg       <= wrap_inc(tail_reg);
                            fill_reg       <= fill_reg + 1'b1;
                        end
                        state_reg <= S_IDLE;
                    end
                end

                S_SRV_OUT:
                begin
                    if (out_free)
                    begin
                        out_status_reg <= STAT_OK;
                        out_id_reg     <= rd_id;
                        out_last_reg   <= 1'b1;
                        head_reg       <= wrap_inc(head_reg);
                        fill_reg       <= fill_reg - 1'b1;
                        state_reg      <= S_IDLE;
                    end
                end

                S_LIST_OUT:
                begin
                    // emit current entry, fetch the next in the same cycle
                    if (out_free)
                    begin
                        out_status_reg <= STAT_OK;
                        out_id_reg     <= rd_id;
                        out_last_reg   <= (cnt_reg == fill_reg);
                        if (cnt_reg == fill_reg)
                        begin
                            if (clr_reg)
                            begin
                                head_reg <= '0;
                                tail_reg <= '0;
                                fill_reg <= '0;
                            end
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            scan_ptr_reg <= wrap_inc(scan_ptr_reg);
                            cnt_reg      <= cnt_reg + 1'b1;
                        end
                    end
                end

                S_ONE_RES:
                begin
                    if (out_free)
                    begin
                        out_status_reg <= res_status_reg;
                        out_id_reg     <= '0;
                        out_last_reg   <= 1'b1;
                        if (clr_reg)
                        begin
                            head_reg <= '0;
                            tail_reg <= '0;
                            fill_reg <= '0;
                        end
                        state_reg <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/unique_id_fifo_queue_unit.sv =====
// Top level of the unique-ID FIFO queue: stream ports, controller and entry store.
`timescale 1ns / 1ps
`default_nettype none

// First-in first-out queue of record IDs that refuses duplicates. Each command
// transfer on the slave side carries a mode in s_tuser (join, serve, list,
// finish, close) and, for join, an ID in s_tdata; results leave on the master
// side with the status in m_tuser, the ID in m_tdata and m_tlast on the final
// result of a command. Commands are taken one at a time: s_tready is high only
// while no command is in progress, and a result may still wait in the output
// register. The entries sit in a single-port-read memory, one read per cycle.
// Join scans every queued entry for a duplicate before it gives its result,
// and a stalled master side holds back the next command. All entries between
// head and tail have been written, so no clearing pass runs after reset.

module unique_id_fifo_queue_unit
    import uidq_pkg::*;
#(
    parameter int DEPTH    = DEF_DEPTH,
    parameter int ID_WIDTH = DEF_ID_WIDTH
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    // command stream
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [REC_W-1:0]    s_tdata,   // [15:0] record_id
    input  wire logic [MODE_W-1:0]   s_tuser,   // [2:0] mode
    // result stream
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic      [REC_W-1:0]    m_tdata,   // [15:0] record_id_res
    output logic      [STATUS_W-1:0] m_tuser,   // [2:0] status
    output logic                     m_tlast
);

    localparam int PW = $clog2(DEPTH);

    logic [31:0]         id_wide;
    logic [ID_WIDTH-1:0] in_id;
    logic                rd_en;
    logic [PW-1:0]       rd_addr;
    logic [ID_WIDTH-1:0] rd_data;
    logic                wr_en;
    logic [PW-1:0]       wr_addr;
    logic [ID_WIDTH-1:0] wr_data;

    // Incoming ID cut or extended to the stored width
    assign id_wide = 32'(s_tdata);
    assign in_id   = id_wide[ID_WIDTH-1:0];

    uidq_ctrl #(
        .DEPTH    (DEPTH),
        .ID_WIDTH (ID_WIDTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_mode    (s_tuser),
        .in_id      (in_id),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (m_tuser),
        .out_id     (m_tdata),
        .out_last   (m_tlast),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data)
    );

    uidq_mem #(
        .DEPTH (DEPTH),
        .WIDTH (ID_WIDTH)
    ) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

endmodule

`default_nettype wire

// ===== rtl/uidq_checker.sv =====
// Port-level checker for the unique-ID FIFO queue and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module uidq_checker
    import uidq_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                s_tvalid,
    input wire logic                s_tready,
    input wire logic [REC_W-1:0]    s_tdata,
    input wire logic [MODE_W-1:0]   s_tuser,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [REC_W-1:0]    m_tdata,
    input wire logic [STATUS_W-1:0] m_tuser,
    input wire logic                m_tlast
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result changed while stalled");

    // Any non-ok status is a single result of its command
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != STAT_OK) |-> m_tlast)
        else $error("non-ok status without tlast");

    // Non-ok results carry no ID
    a_err_noid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != STAT_OK) |-> (m_tdata == '0))
        else $error("non-ok status with an ID");

    // A join always runs a scan, so the next command waits
    a_join_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == MODE_JOIN) |=> !s_tready)
        else $error("command taken during duplicate scan");

endmodule

bind unique_id_fifo_queue_unit uidq_checker u_uidq_checker (.*);

`default_nettype wire

// ===== tb/uidq_checker.sv =====
// Checker for the unique-ID FIFO queue: predicts results from command transfers and compares them.
`timescale 1ns / 1ps

module uidq_tb_checker
    import uidq_pkg::*;
#(
    parameter int DEPTH    = DEF_DEPTH,
    parameter int ID_WIDTH = DEF_ID_WIDTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [REC_W-1:0]    s_tdata,   // [15:0] record_id
    input  logic [MODE_W-1:0]   s_tuser,   // [2:0] mode
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [REC_W-1:0]    m_tdata,   // [15:0] record_id_res
    input  logic [STATUS_W-1:0] m_tuser,   // [2:0] status
    input  logic                m_tlast,
    output int                  mismatch_count,
    output int                  results_due
);

    localparam logic [REC_W-1:0] ID_MASK = REC_W'((64'd1 << ID_WIDTH) - 1);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [REC_W-1:0]    rec_id;
        logic                last;
    } queue_result_t;

    // Shadow copy of the queue
    logic [REC_W-1:0] shadow_ids [DEPTH];
    int               shadow_head;
    int               shadow_tail;
    int               shadow_fill;

    queue_result_t    due_q [$];
    int               bad_results;
    int               due_count;

    assign mismatch_count = bad_results;
    assign results_due    = due_count;

    function automatic int wrap_inc(input int p);
        return (p + 1 >= DEPTH) ? 0 : p + 1;
    endfunction

    function automatic void push_result(input logic [STATUS_W-1:0] st,
                                        input logic [REC_W-1:0] rec,
                                        input logic lst);
        queue_result_t r;
        r.status = st;
        r.rec_id = rec;
        r.last   = lst;
        due_q.push_back(r);
    endfunction

    function automatic void clear_shadow();
        shadow_head = 0;
        shadow_tail = 0;
        shadow_fill = 0;
    endfunction

    // Emit every queued ID head first, or a single empty status
    function automatic void list_shadow();
        int p;
        p = shadow_head;
        if (shadow_fill == 0)
        begin
            push_result(STAT_EMPTY, '0, 1'b1);
        end
        else
        begin
            for (int i = 0; i < shadow_fill; i++)
            begin
                push_result(STAT_OK, shadow_ids[p], (i + 1 == shadow_fill));
                p = wrap_inc(p);
            end
        end
    endfunction

    // Work out the results of one command and update the shadow queue
    function automatic void predict_command(input logic [MODE_W-1:0] mode,
                                            input logic [REC_W-1:0] rec_in);
        logic [REC_W-1:0] rec;
        bit               dup;
        int               p;
        rec = rec_in & ID_MASK;
        dup = 1'b0;
        p   = shadow_head;
        case (mode)
            MODE_JOIN:
            begin
                for (int i = 0; i < shadow_fill; i++)
                begin
                    if (shadow_ids[p] == rec)
                        dup = 1'b1;
                    p = wrap_inc(p);
                end
                if (dup)
                    push_result(STAT_DUP, '0, 1'b1);
                else if (shadow_fill >= DEPTH)
                    push_result(STAT_FULL, '0, 1'b1);
                else
                begin
                    shadow_ids[shadow_tail] = rec;
                    shadow_tail = wrap_inc(shadow_tail);
                    shadow_fill++;
                    push_result(STAT_OK, '0, 1'b1);
                end
            end
            MODE_SERVE:
            begin
                if (shadow_fill == 0)
                    push_result(STAT_EMPTY, '0, 1'b1);
                else
                begin
                    push_result(STAT_OK, shadow_ids[shadow_head], 1'b1);
                    shadow_head = wrap_inc(shadow_head);
                    shadow_fill--;
                end
            end
            MODE_LIST:
                list_shadow();
            MODE_FINISH:
            begin
                list_shadow();
                clear_shadow();
            end
            MODE_CLOSE:
            begin
                push_result((shadow_fill != 0) ? STAT_LEFT : STAT_OK, '0, 1'b1);
                clear_shadow();
            end
            default:
                ;  // unused modes: no result, no state change
        endcase
    endfunction

    // Watch both channels; command side first so a same-edge result finds its entry
    always @(posedge clk or negedge rst_n)
    begin
        queue_result_t want;
        if (!rst_n)
        begin
            clear_shadow();
            due_q.delete();
            due_count   = 0;
            bad_results = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_command(s_tuser, s_tdata);

            if (m_tvalid && m_tready)
            begin
                if (due_q.size() == 0)
                begin
                    if (bad_results < 10)
                        $display("%0t: unexpected result: status %0d id %h last %b",
                                 $realtime, m_tuser, m_tdata, m_tlast);
                    bad_results++;
                end
                else
                begin
                    want = due_q.pop_front();
                    if (want.status !== m_tuser || want.rec_id !== m_tdata ||
                        want.last !== m_tlast)
                    begin
                        if (bad_results < 10)
                            $display({"%0t: result mismatch: exp status %0d id %h last %b,",
                                      " got status %0d id %h last %b"}, $realtime,
                                     want.status, want.rec_id, want.last,
                                     m_tuser, m_tdata, m_tlast);
                        bad_results++;
                    end
                end
            end
            due_count = due_q.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the unique-ID FIFO queue: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
    import uidq_pkg::*;

    localparam int               CYCLE_LIMIT    = 400000;
    localparam int               HOLD_CYCLES    = 400;
    localparam int               TAIL_CYCLES    = 100;
    localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [REC_W-1:0]    s_tdata;   // [15:0] record_id
    logic [MODE_W-1:0]   s_tuser;   // [2:0] mode
    logic                m_tvalid;
    logic                m_tready;
    logic [REC_W-1:0]    m_tdata;   // [15:0] record_id_res
    logic [STATUS_W-1:0] m_tuser;   // [2:0] status
    logic                m_tlast;

    int                  mismatch_count;
    int                  results_due;
    bit                  hold_off_req;
    int                  burst_left;
    logic [REC_W-1:0]    recent_ids [8];
    int                  recent_wr;

    unique_id_fifo_queue_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    uidq_tb_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .results_due    (results_due)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Run limit
    initial
    begin
        int cycles;
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Result side: shifting stall styles, plus one long hold-off on request
    initial
    begin
        int style;
        int left;
        bit hold_done;
        style     = 0;
        left      = 0;
        hold_done = 1'b0;
        m_tready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req && !hold_done)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                if (left == 0)
                begin
                    style = $urandom_range(0, 3);
                    left  = $urandom_range(8, 80);
                end
                left--;
                case (style)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    // Drop valid with junk on the payload; n sets the length of the pause
    task automatic idle_cmd(input int n);
        @(negedge clk);
        s_tvalid <= 1'b0;
        s_tdata  <= REC_W'($urandom);
        s_tuser  <= MODE_W'($urandom);
        repeat (n - 1) @(negedge clk);
    endtask

    // Offer one command inside the current burst and wait for its transfer
    task automatic send_cmd(input logic [MODE_W-1:0] mode, input logic [REC_W-1:0] rec);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
                idle_cmd(gap);
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= rec;
        s_tuser  <= mode;
        do
            @(posedge clk);
        while (!(s_tvalid && s_tready));
    endtask

    task automatic join_id(input logic [REC_W-1:0] rec);
        recent_ids[recent_wr] = rec;
        recent_wr = (recent_wr + 1) % 8;
        send_cmd(MODE_JOIN, rec);
    endtask

    // Pause the command side until every predicted result has arrived
    task automatic drain_results();
        idle_cmd(1);
        while (results_due != 0)
            @(negedge clk);
    endtask

    // Join 33 IDs (the first 32 distinct in their top bits), then a duplicate while full, then list
    task automatic fill_to_full();
        logic [REC_W-1:0] first_id;
        first_id = {5'd0, 11'($urandom)};
        join_id(first_id);
        for (int i = 1; i < 33; i++)
            join_id({5'(i), 11'($urandom)});
        send_cmd(MODE_JOIN, first_id);
        send_cmd(MODE_LIST, REC_W'($urandom));
    endtask

    // One random command; join_pct sets the share of joins
    task automatic random_cmd(input int join_pct);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < join_pct)
        begin
            if ($urandom_range(0, 2) == 0)
                join_id(recent_ids[$urandom_range(0, 7)]);
            else
                join_id(REC_W'($urandom));
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                send_cmd(MODE_SERVE, REC_W'($urandom));
            else if (pick < 72)
                send_cmd(MODE_LIST, REC_W'($urandom));
            else if (pick < 82)
                send_cmd(MODE_FINISH, REC_W'($urandom));
            else if (pick < 90)
                send_cmd(MODE_CLOSE, REC_W'($urandom));
            else
                send_cmd(MODE_W'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI)),
                         REC_W'($urandom));
        end
    endtask

    // Stimulus and verdict
    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = MODE_JOIN;
        hold_off_req = 1'b0;
        burst_left   = 0;
        recent_wr    = 0;
        for (int i = 0; i < 8; i++)
            recent_ids[i] = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty-queue cases, extremes, duplicates, unused modes
        send_cmd(MODE_CLOSE, 16'hFFFF);
        send_cmd(MODE_SERVE, 16'h0000);
        send_cmd(MODE_LIST, 16'h0000);
        send_cmd(MODE_FINISH, 16'h0000);
        join_id(16'h0000);
        join_id(16'hFFFF);
        join_id(16'h0000);
        join_id(16'h8000);
        send_cmd(MODE_LIST, 16'h0000);
        send_cmd(MODE_SERVE, 16'hFFFF);
        send_cmd(MODE_UNUSED_LO, 16'h1111);
        send_cmd(MODE_UNUSED_HI, 16'hFFFF);
        join_id(16'h5555);
        join_id(16'hAAAA);
        send_cmd(MODE_FINISH, 16'h0000);
        send_cmd(MODE_LIST, 16'h0000);
        join_id(16'h1234);
        send_cmd(MODE_CLOSE, 16'h0000);
        send_cmd(MODE_SERVE, 16'h0000);
        join_id(16'h0001);
        send_cmd(MODE_SERVE, 16'h0000);
        join_id(16'h0001);
        drain_results();

        // Full queue: full status, duplicate precedence, longest list
        fill_to_full();

        // Random phases alternating between filling and draining
        for (int ph = 0; ph < 12; ph++)
        begin
            if (ph == 4)
                hold_off_req = 1'b1;
            if (ph == 6)
                fill_to_full();
            repeat (30) random_cmd((ph % 2 == 0) ? 80 : 30);
            if (ph == 7)
                drain_results();
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && results_due == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
